/* hdl/imm_pkg.sv */
`timescale 1ns / 1ps

package imm_pkg;

    // Width of every configuration register.
    localparam int REG_W = 4;

    // Input item modes.
    typedef enum logic [1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ROW_BEGIN  = 3'd0,
        REG_ROW_END    = 3'd1,
        REG_INNER_SIZE = 3'd2,
        REG_B_ROWS     = 3'd3,
        REG_B_COLS     = 3'd4
    } reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [REG_W-1:0] RST_ROW_BEGIN  = 4'd0;
    localparam logic [REG_W-1:0] RST_ROW_END    = 4'd8;
    localparam logic [REG_W-1:0] RST_INNER_SIZE = 4'd8;
    localparam logic [REG_W-1:0] RST_B_ROWS     = 4'd8;
    localparam logic [REG_W-1:0] RST_B_COLS     = 4'd8;

    typedef struct packed {
        logic [REG_W-1:0] row_begin;
        logic [REG_W-1:0] row_end;
        logic [REG_W-1:0] inner_size;
        logic [REG_W-1:0] b_rows;
        logic [REG_W-1:0] b_cols;
    } cfg_t;

    // Store write commands from the controller.
    typedef struct packed {
        logic wr_a;
        logic wr_b;
    } load_cmd_t;

    // One multiply-accumulate beat issued by the controller.
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last_k;
        logic       zero;
        logic       last_item;
        logic [2:0] row;
        logic [2:0] col;
        status_t    status;
    } beat_t;

endpackage

/* hdl/integer_matrix_multiply_unit.sv */
`timescale 1ns / 1ps

// Channel    Handshake                      Beat contents
// input      start high while busy low      mode, elem_row, elem_col, elem_value
// result     result_valid for one cycle     out_row, out_col, out_value, status, last
// config     APB write, psel&penable&pwrite row_begin, row_end, inner_size, b_rows, b_cols
//
// A load item leaves busy low, so loads may follow back to back.
// A compute item holds busy high while it walks its rows, columns and dot-product
// terms and until the pipeline drains; the single multiply-accumulate unit, fed by
// one read port on each element store, takes one product term per cycle.
// A mismatch or empty-range compute issues one status beat and holds busy until it drains.
// rst_n clears control and config state at once; stores and data registers are not.
// Results cannot be stalled: each is shown for exactly one cycle.

module integer_matrix_multiply_unit #(
    parameter int MAX_DIM = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [2:0]         elem_row,
    input  logic [2:0]         elem_col,
    input  logic signed [31:0] elem_value,
    output logic               result_valid,
    output logic [2:0]         out_row,
    output logic [2:0]         out_col,
    output logic signed [31:0] out_value,
    output logic [1:0]         status,
    output logic               last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    imm_pkg::cfg_t      cfg;
    imm_pkg::load_cmd_t load_cmd;
    imm_pkg::beat_t     beat;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic               pipe_busy;

    // Configuration registers.
    imm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer over rows, columns and dot-product terms.
    imm_ctrl #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .elem_row  (elem_row),
        .elem_col  (elem_col),
        .cfg       (cfg),
        .pipe_busy (pipe_busy),
        .busy      (busy),
        .load_cmd  (load_cmd),
        .beat      (beat),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b)
    );

    // Element stores and multiply-accumulate pipeline.
    imm_dp #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_row     (elem_row),
        .elem_col     (elem_col),
        .elem_value   (elem_value),
        .load_cmd     (load_cmd),
        .beat         (beat),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .pipe_busy    (pipe_busy),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .status       (status),
        .last         (last)
    );

endmodule

/* hdl/imm_regs.sv */
`timescale 1ns / 1ps

module imm_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output imm_pkg::cfg_t     cfg
);

    imm_pkg::cfg_t    cfg_reg;
    imm_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = imm_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes on the access cycle of a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_begin  <= imm_pkg::RST_ROW_BEGIN;
            cfg_reg.row_end    <= imm_pkg::RST_ROW_END;
            cfg_reg.inner_size <= imm_pkg::RST_INNER_SIZE;
            cfg_reg.b_rows     <= imm_pkg::RST_B_ROWS;
            cfg_reg.b_cols     <= imm_pkg::RST_B_COLS;
        end
        else if (wr_en)
        begin
            unique case (idx)
                imm_pkg::REG_ROW_BEGIN:  cfg_reg.row_begin  <= pwdata[imm_pkg::REG_W-1:0];
                imm_pkg::REG_ROW_END:    cfg_reg.row_end    <= pwdata[imm_pkg::REG_W-1:0];
                imm_pkg::REG_INNER_SIZE: cfg_reg.inner_size <= pwdata[imm_pkg::REG_W-1:0];
                imm_pkg::REG_B_ROWS:     cfg_reg.b_rows     <= pwdata[imm_pkg::REG_W-1:0];
                imm_pkg::REG_B_COLS:     cfg_reg.b_cols     <= pwdata[imm_pkg::REG_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            imm_pkg::REG_ROW_BEGIN:  prdata[imm_pkg::REG_W-1:0] = cfg_reg.row_begin;
            imm_pkg::REG_ROW_END:    prdata[imm_pkg::REG_W-1:0] = cfg_reg.row_end;
            imm_pkg::REG_INNER_SIZE: prdata[imm_pkg::REG_W-1:0] = cfg_reg.inner_size;
            imm_pkg::REG_B_ROWS:     prdata[imm_pkg::REG_W-1:0] = cfg_reg.b_rows;
            imm_pkg::REG_B_COLS:     prdata[imm_pkg::REG_W-1:0] = cfg_reg.b_cols;
            default:                 prdata = '0;
        endcase
    end

endmodule

/* hdl/imm_ctrl.sv */
`timescale 1ns / 1ps

module imm_ctrl #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         mode,
    input  logic [2:0]         elem_row,
    input  logic [2:0]         elem_col,
    input  imm_pkg::cfg_t      cfg,
    input  logic               pipe_busy,
    output logic               busy,
    output imm_pkg::load_cmd_t load_cmd,
    output imm_pkg::beat_t     beat,
    output logic [AW-1:0]      rd_addr_a,
    output logic [AW-1:0]      rd_addr_b
);

    localparam logic [imm_pkg::REG_W-1:0] MAX_V = imm_pkg::REG_W'(MAX_DIM);

    typedef enum logic [1:0] {
        IDLE,
        WALK,
        DRAIN
    } state_t;

    state_t                    state_reg, state_next;
    imm_pkg::beat_t            beat_reg, beat_next;
    logic [AW-1:0]             addr_a_reg, addr_a_next;
    logic [AW-1:0]             addr_b_reg, addr_b_next;
    logic [imm_pkg::REG_W-1:0] i_reg, i_next;
    logic [imm_pkg::REG_W-1:0] j_reg, j_next;
    logic [imm_pkg::REG_W-1:0] k_reg, k_next;
    logic [imm_pkg::REG_W-1:0] re_reg, re_next;
    logic [imm_pkg::REG_W-1:0] n_reg, n_next;
    logic [imm_pkg::REG_W-1:0] nc_reg, nc_next;

    logic                      accept;
    logic                      in_range;
    logic [imm_pkg::REG_W-1:0] re_sat, n_sat, nc_sat;
    logic                      last_k, last_j, last_i;

    assign accept   = start && (state_reg == IDLE);
    assign busy     = (state_reg != IDLE);
    assign beat     = beat_reg;
    assign rd_addr_a = addr_a_reg;
    assign rd_addr_b = addr_b_reg;

    // Clamp row_end, inner_size and b_cols to the store size.
    assign re_sat = (cfg.row_end > MAX_V) ? MAX_V : cfg.row_end;
    assign n_sat  = (cfg.inner_size > MAX_V) ? MAX_V : cfg.inner_size;
    assign nc_sat = (cfg.b_cols > MAX_V) ? MAX_V : cfg.b_cols;

    assign in_range = ({1'b0, elem_row} < MAX_V) && ({1'b0, elem_col} < MAX_V);

    // Store writes for load items.
    always_comb
    begin
        load_cmd.wr_a = 1'b0;
        load_cmd.wr_b = 1'b0;
        if (accept && in_range)
        begin
            unique case (mode)
                imm_pkg::MODE_LOAD_A: load_cmd.wr_a = 1'b1;
                imm_pkg::MODE_LOAD_B: load_cmd.wr_b = 1'b1;
                default:              ;
            endcase
        end
    end

    // Position of the walk within the dot product, the row and the range.
    assign last_k = (n_reg == '0) || (k_reg == n_reg - 1'b1);
    assign last_j = (j_reg == nc_reg - 1'b1);
    assign last_i = (i_reg == re_reg - 1'b1);

    // Next-state logic and beat issue.
    always_comb
    begin
        state_next  = state_reg;
        beat_next   = '0;
        addr_a_next = addr_a_reg;
        addr_b_next = addr_b_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        re_next     = re_reg;
        n_next      = n_reg;
        nc_next     = nc_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (accept && mode == imm_pkg::MODE_COMPUTE)
                begin
                    if (cfg.inner_size != cfg.b_rows)
                    begin
                        beat_next.valid     = 1'b1;
                        beat_next.first     = 1'b1;
                        beat_next.last_k    = 1'b1;
                        beat_next.zero      = 1'b1;
                        beat_next.last_item = 1'b1;
                        beat_next.status    = imm_pkg::ST_MISMATCH;
                        state_next          = DRAIN;
                    end
                    else if (cfg.row_begin >= re_sat || nc_sat == '0)
                    begin
                        beat_next.valid     = 1'b1;
                        beat_next.first     = 1'b1;
                        beat_next.last_k    = 1'b1;
                        beat_next.zero      = 1'b1;
                        beat_next.last_item = 1'b1;
                        beat_next.status    = imm_pkg::ST_EMPTY;
                        state_next          = DRAIN;
                    end
                    else
                    begin
                        i_next     = cfg.row_begin;
                        j_next     = '0;
                        k_next     = '0;
                        re_next    = re_sat;
                        n_next     = n_sat;
                        nc_next    = nc_sat;
                        state_next = WALK;
                    end
                end
            end

            WALK:
            begin
                beat_next.valid     = 1'b1;
                beat_next.first     = (k_reg == '0);
                beat_next.last_k    = last_k;
                beat_next.zero      = (n_reg == '0);
                beat_next.last_item = last_k && last_j && last_i;
                beat_next.row       = i_reg[2:0];
                beat_next.col       = j_reg[2:0];
                beat_next.status    = imm_pkg::ST_OK;
                addr_a_next = AW'(i_reg) * AW'(MAX_DIM) + AW'(k_reg);
                addr_b_next = AW'(k_reg) * AW'(MAX_DIM) + AW'(j_reg);
                if (last_k)
                begin
                    k_next = '0;
                    if (last_j)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    if (last_j && last_i)
                    begin
                        state_next = DRAIN;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            DRAIN:
            begin
                if (!beat_reg.valid && !pipe_busy)
                begin
                    state_next = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            beat_reg   <= '0;
            addr_a_reg <= '0;
            addr_b_reg <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            re_reg     <= '0;
            n_reg      <= '0;
            nc_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            beat_reg   <= beat_next;
            addr_a_reg <= addr_a_next;
            addr_b_reg <= addr_b_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            re_reg     <= re_next;
            n_reg      <= n_next;
            nc_reg     <= nc_next;
        end
    end

endmodule

/* hdl/imm_dp.sv */
`timescale 1ns / 1ps

module imm_dp #(
    parameter int MAX_DIM = 8,
    parameter int AW      = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         elem_row,
    input  logic [2:0]         elem_col,
    input  logic signed [31:0] elem_value,
    input  imm_pkg::load_cmd_t load_cmd,
    input  imm_pkg::beat_t     beat,
    input  logic [AW-1:0]      rd_addr_a,
    input  logic [AW-1:0]      rd_addr_b,
    output logic               pipe_busy,
    output logic               result_valid,
    output logic [2:0]         out_row,
    output logic [2:0]         out_col,
    output logic signed [31:0] out_value,
    output logic [1:0]         status,
    output logic               last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [31:0]    a_mem [DEPTH];
    logic [31:0]    b_mem [DEPTH];
    logic [AW-1:0]  wr_addr;

    // Read stage and product stage.
    imm_pkg::beat_t s1_reg, s2_reg;
    logic [31:0]    a_q_reg, b_q_reg;
    logic [31:0]    prod_reg, prod_next;
    logic [31:0]    acc_reg, acc_next;

    // Output register.
    logic           out_valid_reg;
    logic [2:0]     out_row_reg, out_col_reg;
    logic [31:0]    out_value_reg;
    imm_pkg::status_t out_status_reg;
    logic           out_last_reg;

    assign wr_addr = AW'(elem_row) * AW'(MAX_DIM) + AW'(elem_col);

    // Element stores: one write port for loads, one read port for the walk.
    always_ff @(posedge clk)
    begin
        if (load_cmd.wr_a)
        begin
            a_mem[wr_addr] <= elem_value;
        end
        if (load_cmd.wr_b)
        begin
            b_mem[wr_addr] <= elem_value;
        end
        a_q_reg <= a_mem[rd_addr_a];
        b_q_reg <= b_mem[rd_addr_b];
    end

    // Low 32 bits of the product, forced to zero on status and empty beats.
    assign prod_next = s1_reg.zero ? 32'd0 : a_q_reg * b_q_reg;

    // Accumulate, restarting on the first term of each dot product.
    assign acc_next = s2_reg.first ? prod_reg : acc_reg + prod_reg;

    assign pipe_busy = s1_reg.valid || s2_reg.valid;

    // Pipeline control and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= beat;
            s2_reg        <= s1_reg;
            out_valid_reg <= s2_reg.valid && s2_reg.last_k;
        end
    end

    // Datapath payload.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (s2_reg.valid && s2_reg.last_k)
        begin
            out_row_reg    <= s2_reg.row;
            out_col_reg    <= s2_reg.col;
            out_value_reg  <= acc_next;
            out_status_reg <= s2_reg.status;
            out_last_reg   <= s2_reg.last_item;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign out_value    = out_value_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;

endmodule

/* hdl/imm_checker.sv */
`timescale 1ns / 1ps

module imm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         mode,
    input logic               result_valid,
    input logic [1:0]         status,
    input logic               last,
    input logic signed [31:0] out_value
);

    // A status result is always the only, and so the final, beat of its item.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != imm_pkg::ST_OK |-> last)
        else $error("status result without last");

    // A status result carries a zero value.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != imm_pkg::ST_OK |-> out_value == 32'sd0)
        else $error("status result with non-zero value");

    // An accepted compute item makes the block busy.
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode == imm_pkg::MODE_COMPUTE |=> busy)
        else $error("compute accepted but block not busy");

    // Loads and unused modes leave the block free for the next item.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && mode != imm_pkg::MODE_COMPUTE |=> !busy)
        else $error("load item made the block busy");

    // No result follows directly after the final one.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result beat directly after last");

endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .result_valid (result_valid),
    .status       (status),
    .last         (last),
    .out_value    (out_value)
);
